/* rtl/tsfr_pkg.sv */
// ----------------------------------------------------------------------------
// tsfr_pkg
// Shared types, constants and the crc-16/modbus byte update for the torque
// and speed frame receiver.
// ----------------------------------------------------------------------------
package tsfr_pkg;

   localparam logic [15:0] CRC_INIT       = 16'hFFFF;
   localparam logic [15:0] CRC_POLY       = 16'hA001;
   localparam logic [12:0] PI_OVER_30_Q16 = 13'd6863;
   localparam logic [43:0] ROUND_HALF     = 44'h0_0000_8000;
   localparam logic [3:0]  ERROR_LIMIT_RESET = 4'd3;

   localparam logic [2:0]  POS_FIRST  = 3'd0;
   localparam logic [2:0]  POS_CRC_LO = 3'd4;
   localparam logic [2:0]  POS_LAST   = 3'd5;

   // controller commands to the datapath
   typedef struct packed {
      logic store;       // request taken: update position, crc, frame bytes
      logic load_err;    // crc mismatch: load error response
      logic start_mul;   // good frame: latch torque x speed product
      logic mul2;        // scale by pi/30
      logic load_ok;     // round and load good response
   } cmd_type;

   // datapath status to the controller
   typedef struct packed {
      logic last_byte;   // next byte completes a frame
      logic restart;     // request carries a restart
      logic crc_match;   // received crc equals the running crc
      logic out_full;    // response register occupied
   } status_type;

   function automatic logic [15:0] crc_add(input logic [15:0] crc,
                                           input logic [7:0]  data);
      logic [15:0] c;
      c = crc ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      return c;
   endfunction

endpackage

/* rtl/tsfr_ctrl.sv */
// ----------------------------------------------------------------------------
// tsfr_ctrl
// Controller: takes requests and sequences the power computation of a good
// frame over two multiply steps and a rounding step.
// ----------------------------------------------------------------------------
module tsfr_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  tsfr_pkg::status_type  status,
   output tsfr_pkg::cmd_type     cmd
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       take;

   // the frame-completing byte waits until the response register is free
   assign req_ready = (state_ff == ST_IDLE) && (!status.last_byte || !status.out_full);
   assign take      = req_valid && req_ready;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               cmd.store = 1'b1;
               if (status.last_byte && !status.restart) begin
                  if (status.crc_match) begin
                     cmd.start_mul = 1'b1;
                     state_in      = ST_MUL;
                  end else begin
                     cmd.load_err = 1'b1;
                  end
               end
            end
         end
         ST_MUL: begin
            cmd.mul2 = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.load_ok = 1'b1;
            state_in    = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_mul_follows: assert property (@(posedge clock) disable iff (reset)
      cmd.start_mul |=> cmd.mul2 ##1 cmd.load_ok)
      else $error("power sequence broken");

   a_busy_no_take: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> !cmd.store)
      else $error("request taken while busy");

endmodule

/* rtl/tsfr_datapath.sv */
// ----------------------------------------------------------------------------
// tsfr_datapath
// Frame position, running crc, frame bytes, error count, power multiplier
// and the response register.
// ----------------------------------------------------------------------------
module tsfr_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  tsfr_pkg::cmd_type     cmd,
   output tsfr_pkg::status_type  status,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_restart,
   input  logic                  csr_wr_en,
   input  logic [3:0]            csr_wr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic                  rsp_frame_ok,
   output logic                  rsp_reconnect_request,
   output logic signed [16:0]    rsp_torque_tenths,
   output logic [14:0]           rsp_shaft_speed,
   output logic signed [28:0]    rsp_power_tenths
);

   logic [3:0]  error_limit_ff;
   logic [2:0]  pos_ff;
   logic [2:0]  pos_eff;
   logic [15:0] crc_ff;
   logic [3:0]  err_ff;
   logic [3:0]  err_in;
   logic [7:0]  frame_ff [5];
   logic        rsp_valid_ff;

   logic        neg_ff;
   logic [14:0] speed_ff;
   logic [15:0] mag_ff;
   logic [30:0] prod1_ff;
   logic [43:0] prod2_ff;
   logic [43:0] rounded;
   logic [27:0] pw;
   logic [15:0] mag_now;
   logic [14:0] speed_now;

   logic        frame_ok_ff;
   logic        reconnect_ff;
   logic [16:0] torque_ff;
   logic [14:0] speed_out_ff;
   logic [28:0] power_ff;

   // stray positions count as the first byte
   assign pos_eff = (pos_ff > tsfr_pkg::POS_LAST) ? tsfr_pkg::POS_FIRST : pos_ff;

   assign status.last_byte = (pos_eff == tsfr_pkg::POS_LAST);
   assign status.restart   = req_restart;
   assign status.crc_match = ({req_data_byte, frame_ff[4]} == crc_ff);
   assign status.out_full  = rsp_valid_ff;

   assign err_in    = err_ff + 4'd1;
   assign mag_now   = {frame_ff[0], frame_ff[1]};
   assign speed_now = {frame_ff[2][6:0], frame_ff[3]};
   assign rounded   = prod2_ff + tsfr_pkg::ROUND_HALF;
   assign pw        = rounded[43:16];

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         error_limit_ff <= tsfr_pkg::ERROR_LIMIT_RESET;
         pos_ff         <= tsfr_pkg::POS_FIRST;
         crc_ff         <= tsfr_pkg::CRC_INIT;
         err_ff         <= 4'd0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            error_limit_ff <= csr_wr_data;
         end
         if (cmd.store) begin
            if (req_restart) begin
               pos_ff <= tsfr_pkg::POS_FIRST;
               crc_ff <= tsfr_pkg::CRC_INIT;
               err_ff <= 4'd0;
            end else if (pos_eff < tsfr_pkg::POS_CRC_LO) begin
               crc_ff <= tsfr_pkg::crc_add(crc_ff, req_data_byte);
               pos_ff <= pos_eff + 3'd1;
            end else if (pos_eff == tsfr_pkg::POS_CRC_LO) begin
               pos_ff <= tsfr_pkg::POS_LAST;
            end else begin
               pos_ff <= tsfr_pkg::POS_FIRST;
               crc_ff <= tsfr_pkg::CRC_INIT;
            end
         end
         if (cmd.start_mul) begin
            err_ff <= 4'd0;
         end else if (cmd.load_err) begin
            err_ff <= (err_in >= error_limit_ff) ? 4'd0 : err_in;
         end
         if (cmd.load_err || cmd.load_ok) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      if (cmd.store && !req_restart && (pos_eff <= tsfr_pkg::POS_CRC_LO)) begin
         frame_ff[pos_eff] <= req_data_byte;
      end
      if (cmd.start_mul) begin
         neg_ff   <= frame_ff[2][7];
         speed_ff <= speed_now;
         mag_ff   <= mag_now;
         prod1_ff <= 31'(mag_now) * 31'(speed_now);
      end
      if (cmd.mul2) begin
         prod2_ff <= 44'(prod1_ff) * 44'(tsfr_pkg::PI_OVER_30_Q16);
      end
      if (cmd.load_err) begin
         frame_ok_ff  <= 1'b0;
         reconnect_ff <= (err_in >= error_limit_ff);
         torque_ff    <= 17'd0;
         speed_out_ff <= 15'd0;
         power_ff     <= 29'd0;
      end else if (cmd.load_ok) begin
         frame_ok_ff  <= 1'b1;
         reconnect_ff <= 1'b0;
         torque_ff    <= neg_ff ? (17'd0 - {1'b0, mag_ff}) : {1'b0, mag_ff};
         speed_out_ff <= speed_ff;
         power_ff     <= neg_ff ? (29'd0 - {1'b0, pw}) : {1'b0, pw};
      end
   end

   assign rsp_valid             = rsp_valid_ff;
   assign rsp_frame_ok          = frame_ok_ff;
   assign rsp_reconnect_request = reconnect_ff;
   assign rsp_torque_tenths     = torque_ff;
   assign rsp_shaft_speed       = speed_out_ff;
   assign rsp_power_tenths      = power_ff;

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (pos_ff != 3'd6) && (pos_ff != 3'd7))
      else $error("frame position out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_err || cmd.load_ok) |-> !rsp_valid_ff)
      else $error("response register overwritten");

   a_err_zero_payload: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !frame_ok_ff) |->
         (torque_ff == 17'd0) && (speed_out_ff == 15'd0) && (power_ff == 29'd0))
      else $error("crc error response carries data");

   a_ok_no_reconnect: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && frame_ok_ff) |-> !reconnect_ff)
      else $error("reconnect on good frame");

endmodule

/* rtl/torque_speed_frame_receiver_core.sv */
// ----------------------------------------------------------------------------
// torque_speed_frame_receiver_core
// Assembles six-byte sensor frames, checks crc-16/modbus and reports torque,
// speed and power, or a crc error with a reconnect flag.
// ----------------------------------------------------------------------------
// Usage
//   req_*  : one received byte per request, or a restart (req_restart = 1)
//            that clears the frame position, crc and error count.
//   rsp_*  : one response per sixth byte of a frame; nothing for other bytes.
//   csr_*  : error_limit, written with csr_wr_en while the block is idle.
// Timing
//   bytes 1..5 of a frame and restarts are taken one per cycle, back to back, while no good frame is computing.
//   a crc error loads the response on the accepting edge (visible next cycle).
//   a good frame goes through a torque x speed multiply, a pi/30 scale
//   multiply, then round and load; requests are held off meanwhile.
// Stall
//   bytes 1..5 keep flowing while a response waits; any request at the sixth
//   position, byte or restart, is held until the response register is free.
// Reset
//   synchronous; clears position, crc, error count, the response valid flag,
//   and sets error_limit to 3. frame bytes and response payload are not cleared.
// ----------------------------------------------------------------------------
module torque_speed_frame_receiver_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [7:0]          req_data_byte,
   input  logic                req_restart,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_frame_ok,
   output logic                rsp_reconnect_request,
   output logic signed [16:0]  rsp_torque_tenths,
   output logic [14:0]         rsp_shaft_speed,
   output logic signed [28:0]  rsp_power_tenths,
   input  logic                csr_wr_en,
   input  logic [3:0]          csr_wr_data
);

   tsfr_pkg::cmd_type    cmd;
   tsfr_pkg::status_type status;

   tsfr_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tsfr_datapath u_datapath (
      .clock                 (clock),
      .reset                 (reset),
      .cmd                   (cmd),
      .status                (status),
      .req_data_byte         (req_data_byte),
      .req_restart           (req_restart),
      .csr_wr_en             (csr_wr_en),
      .csr_wr_data           (csr_wr_data),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_frame_ok          (rsp_frame_ok),
      .rsp_reconnect_request (rsp_reconnect_request),
      .rsp_torque_tenths     (rsp_torque_tenths),
      .rsp_shaft_speed       (rsp_shaft_speed),
      .rsp_power_tenths      (rsp_power_tenths)
   );

endmodule
